>>> design/bpct_pkg.sv
// Shared types and constants for the button press classifier with throttle control.
package bpct_pkg;

    // Field widths.
    localparam int CNT_W     = 8;
    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LEVELS  = 2'd2;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]   LONG_PRESS_TICKS_RST = 8'd100;
    localparam logic [CNT_W-1:0]   DOUBLE_GAP_TICKS_RST = 8'd25;
    localparam logic [LEVEL_W-1:0] THROTTLE_LEVELS_RST  = 8'd4;

    // Press classification codes.
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } press_event_t;

    // Pulses produced by the throttle logic for one tick.
    typedef struct packed {
        logic start_motor;
        logic stop_motor;
        logic enter_sleep;
        logic low_battery_beep;
        logic clear_idle_timer;
    } action_t;

endpackage

>>> design/bpct_if.sv
// Channel interfaces: scan tick input, result output and configuration write.

interface bpct_tick_if;
    logic valid;
    logic ready;
    logic key_level;
    logic battery_low;

    modport source (output valid, output key_level, output battery_low, input ready);
    modport sink   (input valid, input key_level, input battery_low, output ready);
endinterface

interface bpct_result_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    press_event;
    logic [bpct_pkg::LEVEL_W-1:0]  throttle_level;
    logic                          start_motor;
    logic                          stop_motor;
    logic                          enter_sleep;
    logic                          low_battery_beep;
    logic                          clear_idle_timer;

    modport source (
        output valid, output press_event, output throttle_level, output start_motor,
        output stop_motor, output enter_sleep, output low_battery_beep,
        output clear_idle_timer, input ready
    );
    modport sink (
        input valid, input press_event, input throttle_level, input start_motor,
        input stop_motor, input enter_sleep, input low_battery_beep,
        input clear_idle_timer, output ready
    );
endinterface

interface bpct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bpct_pkg::CFG_IDX_W-1:0] index;
    logic [bpct_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bpct_classifier.sv
// Press classifier: four-stage machine with a tick counter sorting short, long and double presses.
module bpct_classifier
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        released,
    input  logic [bpct_pkg::CNT_W-1:0]  long_press_ticks,
    input  logic [bpct_pkg::CNT_W-1:0]  double_gap_ticks,
    output bpct_pkg::press_event_t      press_event
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HELD,
        ST_GAP,
        ST_WAIT_RELEASE
    } stage_t;

    stage_t                       stage_reg;
    stage_t                       stage_next;
    logic [bpct_pkg::CNT_W-1:0]   count_reg;
    logic [bpct_pkg::CNT_W-1:0]   count_next;
    logic [bpct_pkg::CNT_W-1:0]   count_inc;

    assign count_inc = count_reg + 1'b1;

    // Next stage, counter and event for the tick held in the input register.
    always_comb
    begin
        stage_next  = stage_reg;
        count_next  = count_reg;
        press_event = bpct_pkg::EV_NONE;
        unique case (stage_reg)
            ST_IDLE:
            begin
                if (!released)
                begin
                    stage_next = ST_HELD;
                end
            end
            ST_HELD:
            begin
                if (!released)
                begin
                    count_next = count_inc;
                    if (count_inc == long_press_ticks)
                    begin
                        press_event = bpct_pkg::EV_LONG;
                        stage_next  = ST_WAIT_RELEASE;
                    end
                end
                else
                begin
                    stage_next = ST_GAP;
                    count_next = '0;
                end
            end
            ST_GAP:
            begin
                if (released)
                begin
                    count_next = count_inc;
                    if (count_inc == double_gap_ticks)
                    begin
                        press_event = bpct_pkg::EV_SHORT;
                        stage_next  = ST_WAIT_RELEASE;
                    end
                end
                else
                begin
                    press_event = bpct_pkg::EV_DOUBLE;
                    stage_next  = ST_WAIT_RELEASE;
                end
            end
            ST_WAIT_RELEASE:
            begin
                if (released)
                begin
                    stage_next = ST_IDLE;
                    count_next = '0;
                end
            end
        endcase
    end

    // State advances only when a tick moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
            count_reg <= count_next;
        end
    end

    // The event codes fire only from the stages that can produce them.
    a_long_from_held: assert property (@(posedge clk) disable iff (!rst_n)
        (press_event == bpct_pkg::EV_LONG) |-> (stage_reg == ST_HELD && !released))
        else $error("long press outside the held stage");
    a_event_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && press_event != bpct_pkg::EV_NONE) |=> (stage_reg == ST_WAIT_RELEASE))
        else $error("event not followed by wait for release");
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ST_IDLE) |-> (count_reg == '0))
        else $error("tick counter not cleared in idle");

endmodule

>>> design/bpct_throttle.sv
// Throttle step counter and event actions: beep, motor start and stop, sleep request, idle clear.
module bpct_throttle
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  bpct_pkg::press_event_t        press_event,
    input  logic                          battery_low,
    input  logic [bpct_pkg::LEVEL_W-1:0]  throttle_levels,
    output logic [bpct_pkg::LEVEL_W-1:0]  throttle_level,
    output bpct_pkg::action_t             action
);

    logic [bpct_pkg::LEVEL_W-1:0] step_reg;
    logic [bpct_pkg::LEVEL_W-1:0] step_next;
    logic [bpct_pkg::LEVEL_W-1:0] step_inc;

    assign step_inc = step_reg + 1'b1;

    // Act on the classified event of this tick.
    always_comb
    begin
        step_next = step_reg;
        action    = '0;
        action.clear_idle_timer = (press_event != bpct_pkg::EV_NONE);
        case (press_event)
            bpct_pkg::EV_SHORT:
            begin
                if (battery_low)
                begin
                    action.low_battery_beep = 1'b1;
                end
                else
                begin
                    step_next          = step_inc;
                    action.start_motor = (step_inc == 8'd1);
                    if (step_inc == throttle_levels)
                    begin
                        step_next         = '0;
                        action.stop_motor = 1'b1;
                    end
                end
            end
            bpct_pkg::EV_LONG:
            begin
                action.stop_motor  = 1'b1;
                action.enter_sleep = 1'b1;
            end
            bpct_pkg::EV_DOUBLE:
            begin
                action.stop_motor = 1'b1;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    assign throttle_level = step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (advance)
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> design/button_press_classifier_throttle_top.sv
// Top level of the button press classifier with throttle control.
//
// Usage: every transaction on the tick channel is one scan tick carrying the sampled
// button level (0 pressed) and the battery-low flag. Every tick yields exactly one
// transaction on the result channel: the classified press event, the throttle level
// after the tick and one-tick action pulses (motor start/stop, sleep, beep, idle clear).
// Configuration registers (long press ticks, double press gap, throttle levels) are
// written over the cfg channel, which is always ready; write them only while no tick
// is in flight. Index 3 is accepted and ignored.
// An accepted tick waits in the input register and moves into the result register
// once that register is empty or being taken, and is then offered on the result
// channel. Throughput: one tick per cycle while the receiver takes every result;
// the classify and throttle logic between the two registers is combinational.
// Reset clears the press machine, tick counter, throttle step and the valid flags of
// both pipeline registers, and restores the register defaults 100, 25 and 4. When the
// receiver stalls, the result holds and one more tick is taken into the input
// register; the tick channel then deasserts ready until the result moves.
module button_press_classifier_throttle_top
(
    input  logic        clk,
    input  logic        rst_n,
    bpct_tick_if.sink   tick,
    bpct_cfg_if.sink    cfg,
    bpct_result_if.source result
);

    // Configuration registers.
    logic [bpct_pkg::CNT_W-1:0]   long_ticks_reg;
    logic [bpct_pkg::CNT_W-1:0]   gap_ticks_reg;
    logic [bpct_pkg::LEVEL_W-1:0] levels_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg <= bpct_pkg::LONG_PRESS_TICKS_RST;
            gap_ticks_reg  <= bpct_pkg::DOUBLE_GAP_TICKS_RST;
            levels_reg     <= bpct_pkg::THROTTLE_LEVELS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bpct_pkg::REG_LONG_PRESS_TICKS: long_ticks_reg <= cfg.data;
                bpct_pkg::REG_DOUBLE_GAP_TICKS: gap_ticks_reg  <= cfg.data;
                bpct_pkg::REG_THROTTLE_LEVELS:  levels_reg     <= cfg.data;
                default:                        levels_reg     <= levels_reg;
            endcase
        end
    end

    // Input register and handshake control.
    logic in_valid_reg;
    logic key_reg;
    logic bat_reg;
    logic out_valid_reg;
    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            key_reg <= tick.key_level;
            bat_reg <= tick.battery_low;
        end
    end

    // Classification and throttle logic.
    bpct_pkg::press_event_t       ev;
    bpct_pkg::action_t            act;
    logic [bpct_pkg::LEVEL_W-1:0] level;

    bpct_classifier u_classifier
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .released         (key_reg),
        .long_press_ticks (long_ticks_reg),
        .double_gap_ticks (gap_ticks_reg),
        .press_event      (ev)
    );

    bpct_throttle u_throttle
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .press_event     (ev),
        .battery_low     (bat_reg),
        .throttle_levels (levels_reg),
        .throttle_level  (level),
        .action          (act)
    );

    // Result register.
    bpct_pkg::press_event_t       ev_reg;
    bpct_pkg::action_t            act_reg;
    logic [bpct_pkg::LEVEL_W-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg    <= ev;
            act_reg   <= act;
            level_reg <= level;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.press_event      = ev_reg;
    assign result.throttle_level   = level_reg;
    assign result.start_motor      = act_reg.start_motor;
    assign result.stop_motor       = act_reg.stop_motor;
    assign result.enter_sleep      = act_reg.enter_sleep;
    assign result.low_battery_beep = act_reg.low_battery_beep;
    assign result.clear_idle_timer = act_reg.clear_idle_timer;

    // Consistency between the event code and its action pulses.
    a_idle_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.clear_idle_timer ==
                          (result.press_event != bpct_pkg::EV_NONE)))
        else $error("idle timer clear does not match event");
    a_sleep_is_long: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.enter_sleep) |->
            (result.stop_motor && result.press_event == bpct_pkg::EV_LONG))
        else $error("sleep request without a long press");
    a_start_is_short: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.start_motor || result.low_battery_beep)) |->
            (result.press_event == bpct_pkg::EV_SHORT))
        else $error("start or beep without a short press");
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

endmodule
